// ===== sv/dda_line_rasterizer_core_assert.svh =====
// Assertion macros for the line rasterizer.
// Unless ASSERT_OFF is defined, each use expands to one labeled concurrent assertion clocked on clk.
`ifndef DDA_LINE_RASTERIZER_CORE_ASSERT_SVH
`define DDA_LINE_RASTERIZER_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked outside reset only.
`define DLR_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define DLR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DLR_ASSERT_RST(lbl, prop, msg)
`define DLR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== sv/dlr_pkg.sv =====
package dlr_pkg;

  // Number format
  localparam int COORD_INT_BITS  = 12;
  localparam int COORD_FRAC_BITS = 4;
  localparam int ACC_FRAC_BITS   = 16;

  // Item field widths
  localparam int COORD_W  = 16;
  localparam int COLOUR_W = 32;
  localparam int PIX_W    = 12;
  localparam int ADDR_W   = 24;
  localparam int EDGE_W   = 12;  // inclusive tile bounds
  localparam int BOUND_W  = 13;  // exclusive tile bounds and row width
  localparam int COUNT_W  = 13;

  // Derived datapath widths
  localparam int DIFF_W     = COORD_W + 1;
  localparam int MAG_W      = COORD_W;
  localparam int ACC_W      = COORD_INT_BITS + 1 + ACC_FRAC_BITS;
  localparam int STEP_W     = ACC_FRAC_BITS + 2;
  localparam int Q_W        = ACC_FRAC_BITS + 1;
  localparam int REM_W      = MAG_W + 1;
  localparam int DIV_CNT_W  = $clog2(Q_W);
  localparam int SCALE_SH   = ACC_FRAC_BITS - COORD_FRAC_BITS;
  localparam int PX_W       = ACC_W - ACC_FRAC_BITS + 1;
  localparam int PXE_W      = (PX_W > PIX_W) ? PX_W : PIX_W;
  localparam int CMP_W      = (PX_W > BOUND_W) ? PX_W : BOUND_W;
  localparam int MUL_W      = BOUND_W + CMP_W;
  localparam int CNT_RAW_W  = MAG_W - COORD_FRAC_BITS + 1;
  localparam int CNT_CMP_W  = (CNT_RAW_W > COUNT_W) ? CNT_RAW_W : COUNT_W;
  localparam int COUNT_MAX  = (2 ** COUNT_W) - 1;
  localparam int PIX_MIN    = -(2 ** (PIX_W - 1));
  localparam int PIX_MAX    = (2 ** (PIX_W - 1)) - 1;

  // Configuration port
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 5;
  localparam int REG_IDX_W = CFG_AW - 2;

  localparam logic [REG_IDX_W-1:0] REG_TILE_LEFT   = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_TILE_RIGHT  = REG_IDX_W'(1);
  localparam logic [REG_IDX_W-1:0] REG_TILE_TOP    = REG_IDX_W'(2);
  localparam logic [REG_IDX_W-1:0] REG_TILE_BOTTOM = REG_IDX_W'(3);
  localparam logic [REG_IDX_W-1:0] REG_ROW_WIDTH   = REG_IDX_W'(4);

  localparam logic [BOUND_W-1:0] BOUND_RESET = BOUND_W'(4096);

  // Input actions
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_FIN,
    ST_ROUND,
    ST_ADDR
  } dlr_state_t;

  typedef struct packed {
    logic [EDGE_W-1:0]  tile_left;
    logic [BOUND_W-1:0] tile_right;
    logic [EDGE_W-1:0]  tile_top;
    logic [BOUND_W-1:0] tile_bottom;
    logic [BOUND_W-1:0] row_width;
  } dlr_cfg_t;

  typedef struct packed {
    logic load;   // capture a new line from the input item
    logic prep;   // form span, pixel count, divider operands
    logic div;    // one quotient bit per lane
    logic fin;    // commit increments, arm the line
    logic round;  // round accumulators, advance the line
    logic emit;   // write the result register
  } dlr_cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
    logic line_active;
    logic pixels_left_nz;
  } dlr_status_t;

endpackage

// ===== sv/dlr_in_if.sv =====
interface dlr_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 action;
  logic signed [dlr_pkg::COORD_W-1:0]   start_x;
  logic signed [dlr_pkg::COORD_W-1:0]   start_y;
  logic signed [dlr_pkg::COORD_W-1:0]   end_x;
  logic signed [dlr_pkg::COORD_W-1:0]   end_y;
  logic [dlr_pkg::COLOUR_W-1:0]         line_colour;

  modport source (
    output valid, action, start_x, start_y, end_x, end_y, line_colour,
    input  ready
  );
  modport sink (
    input  valid, action, start_x, start_y, end_x, end_y, line_colour,
    output ready
  );
endinterface

// ===== sv/dlr_out_if.sv =====
interface dlr_out_if;
  logic                               valid;
  logic                               ready;
  logic                               pixel_valid;
  logic                               pixel_write;
  logic signed [dlr_pkg::PIX_W-1:0]   pixel_x;
  logic signed [dlr_pkg::PIX_W-1:0]   pixel_y;
  logic [dlr_pkg::ADDR_W-1:0]         pixel_address;
  logic [dlr_pkg::COLOUR_W-1:0]       pixel_colour;
  logic                               last_pixel;

  modport source (
    output valid, pixel_valid, pixel_write, pixel_x, pixel_y, pixel_address,
           pixel_colour, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, pixel_valid, pixel_write, pixel_x, pixel_y, pixel_address,
           pixel_colour, last_pixel,
    output ready
  );
endinterface

// ===== sv/dlr_regs.sv =====
module dlr_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dlr_pkg::CFG_AW-1:0]    paddr,
  input  logic [dlr_pkg::CFG_DW-1:0]    pwdata,
  output logic [dlr_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output dlr_pkg::dlr_cfg_t             cfg
);

  dlr_pkg::dlr_cfg_t                 cfg_r;
  logic [dlr_pkg::REG_IDX_W-1:0]     idx;
  logic                              wr_en;

  assign idx    = paddr[dlr_pkg::CFG_AW-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tile_left   <= '0;
      cfg_r.tile_right  <= dlr_pkg::BOUND_RESET;
      cfg_r.tile_top    <= '0;
      cfg_r.tile_bottom <= dlr_pkg::BOUND_RESET;
      cfg_r.row_width   <= dlr_pkg::BOUND_RESET;
    end else if (wr_en) begin
      case (idx)
        dlr_pkg::REG_TILE_LEFT:   cfg_r.tile_left   <= pwdata[dlr_pkg::EDGE_W-1:0];
        dlr_pkg::REG_TILE_RIGHT:  cfg_r.tile_right  <= pwdata[dlr_pkg::BOUND_W-1:0];
        dlr_pkg::REG_TILE_TOP:    cfg_r.tile_top    <= pwdata[dlr_pkg::EDGE_W-1:0];
        dlr_pkg::REG_TILE_BOTTOM: cfg_r.tile_bottom <= pwdata[dlr_pkg::BOUND_W-1:0];
        dlr_pkg::REG_ROW_WIDTH:   cfg_r.row_width   <= pwdata[dlr_pkg::BOUND_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dlr_pkg::REG_TILE_LEFT:   prdata = dlr_pkg::CFG_DW'(cfg_r.tile_left);
      dlr_pkg::REG_TILE_RIGHT:  prdata = dlr_pkg::CFG_DW'(cfg_r.tile_right);
      dlr_pkg::REG_TILE_TOP:    prdata = dlr_pkg::CFG_DW'(cfg_r.tile_top);
      dlr_pkg::REG_TILE_BOTTOM: prdata = dlr_pkg::CFG_DW'(cfg_r.tile_bottom);
      dlr_pkg::REG_ROW_WIDTH:   prdata = dlr_pkg::CFG_DW'(cfg_r.row_width);
      default:                  prdata = '0;
    endcase
  end

endmodule

// ===== sv/dlr_ctrl.sv =====
module dlr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_action,
  output logic                  in_ready,
  input  dlr_pkg::dlr_status_t  status,
  output dlr_pkg::dlr_cmd_t     cmd
);

  dlr_pkg::dlr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dlr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dlr_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_action == dlr_pkg::ACT_LOAD) ? dlr_pkg::ST_PREP : dlr_pkg::ST_ROUND;
        end
      end
      dlr_pkg::ST_PREP:  state_nxt = dlr_pkg::ST_DIV;
      dlr_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_nxt = dlr_pkg::ST_FIN;
        end
      end
      dlr_pkg::ST_FIN:   state_nxt = dlr_pkg::ST_IDLE;
      dlr_pkg::ST_ROUND: state_nxt = dlr_pkg::ST_ADDR;
      dlr_pkg::ST_ADDR: begin
        // hold until the result register is free
        if (status.out_free) begin
          state_nxt = dlr_pkg::ST_IDLE;
        end
      end
      default: state_nxt = dlr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      dlr_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid && (in_action == dlr_pkg::ACT_LOAD);
      end
      dlr_pkg::ST_PREP:  cmd.prep  = 1'b1;
      dlr_pkg::ST_DIV:   cmd.div   = 1'b1;
      dlr_pkg::ST_FIN:   cmd.fin   = 1'b1;
      dlr_pkg::ST_ROUND: cmd.round = 1'b1;
      dlr_pkg::ST_ADDR:  cmd.emit  = status.out_free;
      default: ;
    endcase
  end

endmodule

// ===== sv/dlr_datapath.sv =====
module dlr_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dlr_pkg::dlr_cmd_t                     cmd,
  output dlr_pkg::dlr_status_t                  status,
  input  dlr_pkg::dlr_cfg_t                     cfg,
  input  logic signed [dlr_pkg::COORD_W-1:0]    start_x,
  input  logic signed [dlr_pkg::COORD_W-1:0]    start_y,
  input  logic signed [dlr_pkg::COORD_W-1:0]    end_x,
  input  logic signed [dlr_pkg::COORD_W-1:0]    end_y,
  input  logic [dlr_pkg::COLOUR_W-1:0]          line_colour,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  pixel_valid,
  output logic                                  pixel_write,
  output logic signed [dlr_pkg::PIX_W-1:0]      pixel_x,
  output logic signed [dlr_pkg::PIX_W-1:0]      pixel_y,
  output logic [dlr_pkg::ADDR_W-1:0]            pixel_address,
  output logic [dlr_pkg::COLOUR_W-1:0]          pixel_colour,
  output logic                                  last_pixel
);

  localparam int ACC_W  = dlr_pkg::ACC_W;
  localparam int PX_W   = dlr_pkg::PX_W;
  localparam int MAG_W  = dlr_pkg::MAG_W;
  localparam int REM_W  = dlr_pkg::REM_W;
  localparam int Q_W    = dlr_pkg::Q_W;
  localparam int STEP_W = dlr_pkg::STEP_W;
  localparam int DIFF_W = dlr_pkg::DIFF_W;
  localparam int CMP_W  = dlr_pkg::CMP_W;
  localparam int PXE_W  = dlr_pkg::PXE_W;

  function automatic logic [ACC_W-1:0] acc_from_coord(input logic [dlr_pkg::COORD_W-1:0] c);
    logic [dlr_pkg::COORD_W+ACC_W-1:0] ext;
    ext = {{ACC_W{c[dlr_pkg::COORD_W-1]}}, c};
    ext = ext << dlr_pkg::SCALE_SH;
    return ext[ACC_W-1:0];
  endfunction

  // round half away from zero to whole pixels
  function automatic logic [PX_W-1:0] round_acc(input logic [ACC_W-1:0] a);
    logic [ACC_W:0]   ext;
    logic [ACC_W:0]   mag;
    logic [ACC_W:0]   sum;
    logic [PX_W-1:0]  r;
    ext = {a[ACC_W-1], a};
    mag = a[ACC_W-1] ? (~ext + 1'b1) : ext;
    sum = mag + ((ACC_W+1)'(1) << (dlr_pkg::ACC_FRAC_BITS - 1));
    r   = sum[ACC_W:dlr_pkg::ACC_FRAC_BITS];
    return a[ACC_W-1] ? (~r + 1'b1) : r;
  endfunction

  function automatic logic signed [PXE_W-1:0] clamp_pix(input logic signed [PX_W-1:0] p);
    logic signed [PXE_W-1:0] e;
    e = PXE_W'(p);
    if (e < dlr_pkg::PIX_MIN) begin
      e = PXE_W'(dlr_pkg::PIX_MIN);
    end else if (e > dlr_pkg::PIX_MAX) begin
      e = PXE_W'(dlr_pkg::PIX_MAX);
    end
    return e;
  endfunction

  // line state
  logic [ACC_W-1:0]                 x_accum_r, y_accum_r;
  logic signed [STEP_W-1:0]         x_step_r, y_step_r;
  logic [dlr_pkg::COUNT_W-1:0]      pixels_left_r;
  logic [dlr_pkg::COLOUR_W-1:0]     held_colour_r;
  logic                             line_active_r;

  // load and divide
  logic [DIFF_W-1:0]                dx_r, dy_r;
  logic                             neg_x_r, neg_y_r, zero_r;
  logic [MAG_W-1:0]                 div_d_r;
  logic [REM_W-1:0]                 rem_x_r, rem_y_r;
  logic [Q_W-1:0]                   q_x_r, q_y_r;
  logic [dlr_pkg::DIV_CNT_W-1:0]    div_cnt_r;

  // pixel stage
  logic signed [PX_W-1:0]           px_r, py_r;
  logic                             last_r, null_r;

  // result register
  logic                             out_valid_r;
  logic                             o_valid_r, o_write_r, o_last_r;
  logic signed [dlr_pkg::PIX_W-1:0] o_x_r, o_y_r;
  logic [dlr_pkg::ADDR_W-1:0]       o_addr_r;
  logic [dlr_pkg::COLOUR_W-1:0]     o_colour_r;

  // prep
  logic [DIFF_W-1:0]                ax_full, ay_full;
  logic [MAG_W-1:0]                 ax, ay, steps;
  logic [dlr_pkg::CNT_CMP_W-1:0]    cnt_ext;
  logic [dlr_pkg::COUNT_W-1:0]      count_sat;

  // divide
  logic                             ge_x, ge_y;
  logic [REM_W-1:0]                 diff_x, diff_y;
  logic [STEP_W-1:0]                mag_x, mag_y;

  // emit
  logic                             in_tile;
  logic [CMP_W-1:0]                 pxu, pyu;
  logic [dlr_pkg::MUL_W-1:0]        addr_sum;
  logic signed [PXE_W-1:0]          cx, cy;

  always_comb begin
    ax_full   = dx_r[DIFF_W-1] ? (~dx_r + 1'b1) : dx_r;
    ay_full   = dy_r[DIFF_W-1] ? (~dy_r + 1'b1) : dy_r;
    ax        = ax_full[MAG_W-1:0];
    ay        = ay_full[MAG_W-1:0];
    steps     = (ax > ay) ? ax : ay;
    cnt_ext   = dlr_pkg::CNT_CMP_W'(steps >> dlr_pkg::COORD_FRAC_BITS) + 1'b1;
    count_sat = (cnt_ext > dlr_pkg::CNT_CMP_W'(dlr_pkg::COUNT_MAX))
                ? dlr_pkg::COUNT_W'(dlr_pkg::COUNT_MAX) : cnt_ext[dlr_pkg::COUNT_W-1:0];
  end

  always_comb begin
    ge_x   = rem_x_r >= REM_W'(div_d_r);
    ge_y   = rem_y_r >= REM_W'(div_d_r);
    diff_x = ge_x ? (rem_x_r - REM_W'(div_d_r)) : rem_x_r;
    diff_y = ge_y ? (rem_y_r - REM_W'(div_d_r)) : rem_y_r;
    mag_x  = STEP_W'(q_x_r);
    mag_y  = STEP_W'(q_y_r);
  end

  always_comb begin
    pxu      = CMP_W'(px_r);
    pyu      = CMP_W'(py_r);
    in_tile  = !px_r[PX_W-1] && !py_r[PX_W-1] &&
               (pxu >= CMP_W'(cfg.tile_left)) && (pxu < CMP_W'(cfg.tile_right)) &&
               (pyu >= CMP_W'(cfg.tile_top))  && (pyu < CMP_W'(cfg.tile_bottom));
    addr_sum = cfg.row_width * pyu + dlr_pkg::MUL_W'(pxu);
    cx       = clamp_pix(px_r);
    cy       = clamp_pix(py_r);
  end

  // load capture, span and divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dx_r <= {end_x[dlr_pkg::COORD_W-1], end_x} - {start_x[dlr_pkg::COORD_W-1], start_x};
      dy_r <= {end_y[dlr_pkg::COORD_W-1], end_y} - {start_y[dlr_pkg::COORD_W-1], start_y};
    end
    if (cmd.prep) begin
      neg_x_r <= dx_r[DIFF_W-1];
      neg_y_r <= dy_r[DIFF_W-1];
      zero_r  <= (steps == '0);
      div_d_r <= steps;
      rem_x_r <= REM_W'(ax);
      rem_y_r <= REM_W'(ay);
      q_x_r   <= '0;
      q_y_r   <= '0;
    end else if (cmd.div) begin
      rem_x_r <= {diff_x[MAG_W-1:0], 1'b0};
      rem_y_r <= {diff_y[MAG_W-1:0], 1'b0};
      q_x_r   <= {q_x_r[Q_W-2:0], ge_x};
      q_y_r   <= {q_y_r[Q_W-2:0], ge_y};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd.prep) begin
      div_cnt_r <= '0;
    end else if (cmd.div) begin
      div_cnt_r <= div_cnt_r + 1'b1;
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_accum_r     <= '0;
      y_accum_r     <= '0;
      x_step_r      <= '0;
      y_step_r      <= '0;
      pixels_left_r <= '0;
      held_colour_r <= '0;
      line_active_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        x_accum_r     <= acc_from_coord(start_x);
        y_accum_r     <= acc_from_coord(start_y);
        held_colour_r <= line_colour;
      end
      if (cmd.prep) begin
        pixels_left_r <= count_sat;
      end
      if (cmd.fin) begin
        x_step_r      <= zero_r ? '0 : (neg_x_r ? -mag_x : mag_x);
        y_step_r      <= zero_r ? '0 : (neg_y_r ? -mag_y : mag_y);
        line_active_r <= 1'b1;
      end
      if (cmd.round) begin
        if (line_active_r && (pixels_left_r != '0)) begin
          x_accum_r     <= x_accum_r + ACC_W'(x_step_r);
          y_accum_r     <= y_accum_r + ACC_W'(y_step_r);
          pixels_left_r <= pixels_left_r - 1'b1;
          if (pixels_left_r == dlr_pkg::COUNT_W'(1)) begin
            line_active_r <= 1'b0;
          end
        end else begin
          line_active_r <= 1'b0;
        end
      end
    end
  end

  // pixel stage
  always_ff @(posedge clk) begin
    if (cmd.round) begin
      px_r   <= round_acc(x_accum_r);
      py_r   <= round_acc(y_accum_r);
      last_r <= (pixels_left_r == dlr_pkg::COUNT_W'(1));
      null_r <= !(line_active_r && (pixels_left_r != '0));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (null_r) begin
        o_valid_r  <= 1'b0;
        o_write_r  <= 1'b0;
        o_x_r      <= '0;
        o_y_r      <= '0;
        o_addr_r   <= '0;
        o_colour_r <= '0;
        o_last_r   <= 1'b0;
      end else begin
        o_valid_r  <= 1'b1;
        o_write_r  <= in_tile;
        o_x_r      <= cx[dlr_pkg::PIX_W-1:0];
        o_y_r      <= cy[dlr_pkg::PIX_W-1:0];
        o_addr_r   <= in_tile ? addr_sum[dlr_pkg::ADDR_W-1:0] : '0;
        o_colour_r <= held_colour_r;
        o_last_r   <= last_r;
      end
    end
  end

  assign status.div_last       = (div_cnt_r == dlr_pkg::DIV_CNT_W'(Q_W - 1));
  assign status.out_free       = !out_valid_r || out_ready;
  assign status.line_active    = line_active_r;
  assign status.pixels_left_nz = (pixels_left_r != '0);

  assign out_valid     = out_valid_r;
  assign pixel_valid   = o_valid_r;
  assign pixel_write   = o_write_r;
  assign pixel_x       = o_x_r;
  assign pixel_y       = o_y_r;
  assign pixel_address = o_addr_r;
  assign pixel_colour  = o_colour_r;
  assign last_pixel    = o_last_r;

endmodule

// ===== sv/dda_line_rasterizer_core.sv =====
// DDA line rasterizer.
// in_chan takes items: action 0 loads a line (two signed 12.4 endpoints and
// a colour), action 1 steps to the next pixel. A load gives no result; every
// step gives exactly one result on out_chan, with pixel_valid 0 when no line
// is active. Tile bounds and row width sit in the cfg_ APB registers.
// Load: in_chan.ready stays low after the accepting edge while a restoring
// divider forms both increments, one quotient bit per cycle; the next item
// is taken once the divider has finished and the increments are committed.
// Step: in_chan.ready stays low while the pixel stage rounds the accumulators
// and the address stage does the tile test and address multiply.
// A finished result sits in an output register; the block takes the next item
// while it waits. If the receiver stalls, the result holds and a following
// step waits in the address stage until the register frees.
// Reset (rst_n low, synchronous) sets the tile to 0..4096 on both axes, row
// width 4096, drops any active line and any pending result.
`include "dda_line_rasterizer_core_assert.svh"

module dda_line_rasterizer_core (
  input  logic                          clk,
  input  logic                          rst_n,
  dlr_in_if.sink                        in_chan,
  dlr_out_if.source                     out_chan,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [dlr_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [dlr_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [dlr_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                          cfg_pready
);

  dlr_pkg::dlr_cfg_t    cfg;
  dlr_pkg::dlr_cmd_t    cmd;
  dlr_pkg::dlr_status_t status;

  dlr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  dlr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_action (in_chan.action),
    .in_ready  (in_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  dlr_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .cfg           (cfg),
    .start_x       (in_chan.start_x),
    .start_y       (in_chan.start_y),
    .end_x         (in_chan.end_x),
    .end_y         (in_chan.end_y),
    .line_colour   (in_chan.line_colour),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .pixel_valid   (out_chan.pixel_valid),
    .pixel_write   (out_chan.pixel_write),
    .pixel_x       (out_chan.pixel_x),
    .pixel_y       (out_chan.pixel_y),
    .pixel_address (out_chan.pixel_address),
    .pixel_colour  (out_chan.pixel_colour),
    .last_pixel    (out_chan.last_pixel)
  );

  `DLR_ASSERT_RST(a_active_has_pixels, status.line_active |-> status.pixels_left_nz, "active line with no pixels left")
  `DLR_ASSERT_RST(a_result_from_emit, $rose(out_chan.valid) |-> $past(cmd.emit), "result raised without emit")
  `DLR_ASSERT_RST(a_load_no_result, (in_chan.valid && in_chan.ready && (in_chan.action == dlr_pkg::ACT_LOAD) && !out_chan.valid) |=> !out_chan.valid, "load item produced a result")
  `DLR_ASSERT_RST(a_busy_after_accept, (in_chan.valid && in_chan.ready) |=> !in_chan.ready, "item taken while busy")
  `DLR_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_chan.valid, "result pending after reset")

endmodule
